/* rtl/core/eeprom_sysinfo_record_parser_macros.svh */
// assertion helpers for the record parser
`ifndef EEPROM_SYSINFO_RECORD_PARSER_MACROS_SVH
`define EEPROM_SYSINFO_RECORD_PARSER_MACROS_SVH

`ifndef SYNTH
`define ESRP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("esrp assertion failed");
`define ESRP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("esrp assertion failed");
`else
`define ESRP_ASSERT(name, prop)
`define ESRP_ASSERT_NEXT(name, pre, post)
`endif

`endif

/* rtl/core/esrp_pkg.sv */
`default_nettype none

package esrp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_value;
    logic [9:0]  position;
    logic [9:0]  record_index;
    logic [9:0]  record_total;
    logic [16:0] image_length;
  } out_t;

  localparam logic [2:0] KindSerial    = 3'd0;
  localparam logic [2:0] KindName      = 3'd1;
  localparam logic [2:0] KindHeaderOk  = 3'd2;
  localparam logic [2:0] KindBadHeader = 3'd3;
  localparam logic [2:0] KindDone      = 3'd4;
  localparam logic [2:0] KindBadRecord = 3'd5;

  localparam int unsigned HeaderBytes = 10;
  localparam int unsigned PrefixBytes = 6;
  localparam logic [7:0]  AsciiZero   = 8'h30;
  localparam logic [7:0]  AsciiNine   = 8'h39;
  localparam logic [7:0]  AsciiCr     = 8'h0d;

endpackage

`default_nettype wire

/* rtl/core/eeprom_sysinfo_record_parser.sv */
`default_nettype none

// Parses a stored system-information image, one byte per beat in address order.
// A beat with start_req set is header byte 0 and restarts the parse. The ten
// header digits give the record count and total length (status beat: header
// ok, bad header, or done for zero records); then each record's newline, six
// prefix bytes with a three-digit data length, and its data bytes, which come
// out as serial bytes (record 0) or name bytes, up to SERIAL_BYTES / NAME_BYTES
// per record. Errors and completion give one status beat, then bytes are
// ignored until the next start_req. Throughput is one byte per cycle while the
// output is not stalled: an input register feeds a single pass of counter and
// digit logic into an output register, and bytes that produce no result are
// absorbed at the same rate.
module eeprom_sysinfo_record_parser
  import esrp_pkg::*;
#(
  parameter int unsigned SERIAL_BYTES = 20,
  parameter int unsigned NAME_BYTES   = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam logic [2:0] PhHeader      = 3'd0;
  localparam logic [2:0] PhNewline     = 3'd1;
  localparam logic [2:0] PhPrefix      = 3'd2;
  localparam logic [2:0] PhData        = 3'd3;
  localparam logic [2:0] PhDonePending = 3'd4;
  localparam logic [2:0] PhStopped     = 3'd5;

  localparam logic [9:0] SerialCap = 10'(SERIAL_BYTES);
  localparam logic [9:0] NameCap   = 10'(NAME_BYTES);

  // input stage
  logic in_valid_q;
  in_t  in_q;

  // parser state
  logic [2:0]  phase_q, phase_d;
  logic [16:0] byte_offset_q, byte_offset_d;
  logic [9:0]  rec_count_q, rec_count_d;
  logic [16:0] len_total_q, len_total_d;
  logic [9:0]  rec_num_q, rec_num_d;
  logic [2:0]  prefix_cnt_q, prefix_cnt_d;
  logic [9:0]  data_len_q, data_len_d;
  logic [9:0]  data_pos_q, data_pos_d;
  logic        skip_nl_q, skip_nl_d;

  // output stage
  logic out_valid_q;
  out_t out_q;

  logic fire;
  logic emit;
  out_t res;

  // state as seen after an optional restart
  logic [2:0]  cur_phase;
  logic [16:0] cur_off;
  logic [9:0]  cur_count;
  logic [16:0] cur_len;
  logic [9:0]  cur_rec;
  logic [2:0]  cur_prefix;
  logic [9:0]  cur_dlen;
  logic [9:0]  cur_dpos;
  logic        cur_skip;

  logic [7:0]  b;
  logic        is_digit;
  logic [3:0]  digit;
  logic [9:0]  rec_inc;
  logic [9:0]  pos_inc;
  logic [9:0]  acc_next;
  logic [9:0]  cap;
  logic        shown;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  assign b        = in_q.data_byte;
  assign is_digit = (b >= AsciiZero) && (b <= AsciiNine);
  assign digit    = is_digit ? b[3:0] : 4'd0;

  always_comb begin
    if (in_q.start_req) begin
      cur_phase  = PhHeader;
      cur_off    = '0;
      cur_count  = '0;
      cur_len    = '0;
      cur_rec    = '0;
      cur_prefix = '0;
      cur_dlen   = '0;
      cur_dpos   = '0;
      cur_skip   = 1'b0;
    end else begin
      cur_phase  = phase_q;
      cur_off    = byte_offset_q;
      cur_count  = rec_count_q;
      cur_len    = len_total_q;
      cur_rec    = rec_num_q;
      cur_prefix = prefix_cnt_q;
      cur_dlen   = data_len_q;
      cur_dpos   = data_pos_q;
      cur_skip   = skip_nl_q;
    end
  end

  assign rec_inc  = cur_rec + 10'd1;
  assign pos_inc  = cur_dpos + 10'd1;
  assign acc_next = 10'((13'(cur_dlen) << 3) + (13'(cur_dlen) << 1) + 13'(digit));
  assign cap      = (cur_rec == '0) ? SerialCap : NameCap;
  assign shown    = cur_dpos < cap;

  always_comb begin
    phase_d       = cur_phase;
    byte_offset_d = cur_off;
    rec_count_d   = cur_count;
    len_total_d   = cur_len;
    rec_num_d     = cur_rec;
    prefix_cnt_d  = cur_prefix;
    data_len_d    = cur_dlen;
    data_pos_d    = cur_dpos;
    skip_nl_d     = cur_skip;
    emit          = 1'b0;
    res           = '0;
    res.record_index = cur_rec;
    res.record_total = cur_count;
    res.image_length = cur_len;

    if (cur_phase != PhStopped && cur_phase != PhDonePending && cur_off != '1) begin
      byte_offset_d = cur_off + 17'd1;
    end

    unique case (cur_phase)
      PhStopped: begin
        emit = 1'b0;
      end
      PhDonePending: begin
        phase_d  = PhStopped;
        emit     = 1'b1;
        res.kind = KindDone;
      end
      PhHeader: begin
        if (!is_digit) begin
          phase_d = PhStopped;
          emit    = 1'b1;
          res     = '0;
          res.kind = KindBadHeader;
        end else begin
          if (cur_off >= 17'd2 && cur_off <= 17'd4) begin
            rec_count_d = 10'((13'(cur_count) << 3) + (13'(cur_count) << 1) + 13'(digit));
          end else if (cur_off >= 17'd5 && cur_off <= 17'(HeaderBytes - 1)) begin
            len_total_d = 17'((20'(cur_len) << 3) + (20'(cur_len) << 1) + 20'(digit));
          end
          if (cur_off >= 17'(HeaderBytes - 1)) begin
            emit = 1'b1;
            res.record_index = cur_rec;
            res.record_total = rec_count_d;
            res.image_length = len_total_d;
            if (rec_count_d == '0) begin
              phase_d  = PhStopped;
              res.kind = KindDone;
            end else begin
              phase_d  = PhNewline;
              res.kind = KindHeaderOk;
            end
          end
        end
      end
      PhNewline, PhPrefix, PhData: begin
        if (cur_off >= cur_len) begin
          byte_offset_d = cur_off + 17'd1;
          if (cur_off == '1) byte_offset_d = cur_off;
          phase_d  = PhStopped;
          emit     = 1'b1;
          res.kind = KindBadRecord;
        end else if (cur_phase == PhNewline) begin
          // a carriage return swallows the byte after it
          if (cur_skip) begin
            skip_nl_d = 1'b0;
            phase_d   = PhPrefix;
          end else if (b == AsciiCr) begin
            skip_nl_d = 1'b1;
          end else begin
            phase_d = PhPrefix;
          end
          prefix_cnt_d = '0;
          data_len_d   = '0;
        end else if (cur_phase == PhPrefix) begin
          if (cur_prefix >= 3'd3 && !is_digit) begin
            phase_d  = PhStopped;
            emit     = 1'b1;
            res.kind = KindBadRecord;
          end else begin
            if (cur_prefix >= 3'd3) data_len_d = acc_next;
            if (cur_prefix < 3'(PrefixBytes - 1)) begin
              prefix_cnt_d = cur_prefix + 3'd1;
            end else begin
              prefix_cnt_d = '0;
              data_pos_d   = '0;
              if (data_len_d == '0) begin
                // empty record closes at once
                rec_num_d  = rec_inc;
                data_len_d = '0;
                skip_nl_d  = 1'b0;
                if (rec_inc == cur_count) begin
                  phase_d  = PhStopped;
                  emit     = 1'b1;
                  res.kind = KindDone;
                  res.record_index = rec_inc;
                end else begin
                  phase_d = PhNewline;
                end
              end else begin
                phase_d = PhData;
              end
            end
          end
        end else begin
          data_pos_d = pos_inc;
          if (pos_inc >= cur_dlen) begin
            rec_num_d    = rec_inc;
            prefix_cnt_d = '0;
            data_len_d   = '0;
            data_pos_d   = '0;
            skip_nl_d    = 1'b0;
            if (rec_inc == cur_count) begin
              phase_d = shown ? PhDonePending : PhStopped;
            end else begin
              phase_d = PhNewline;
            end
          end
          if (shown) begin
            emit           = 1'b1;
            res.kind       = (cur_rec == '0) ? KindSerial : KindName;
            res.data_value = b;
            res.position   = cur_dpos;
            res.record_index = cur_rec;
          end else if (pos_inc >= cur_dlen && rec_inc == cur_count) begin
            emit     = 1'b1;
            res.kind = KindDone;
            res.record_index = rec_inc;
          end
        end
      end
      default: begin
        phase_d = PhStopped;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q       <= PhHeader;
      byte_offset_q <= '0;
      rec_count_q   <= '0;
      len_total_q   <= '0;
      rec_num_q     <= '0;
      prefix_cnt_q  <= '0;
      data_len_q    <= '0;
      data_pos_q    <= '0;
      skip_nl_q     <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        phase_q       <= phase_d;
        byte_offset_q <= byte_offset_d;
        rec_count_q   <= rec_count_d;
        len_total_q   <= len_total_d;
        rec_num_q     <= rec_num_d;
        prefix_cnt_q  <= prefix_cnt_d;
        data_len_q    <= data_len_d;
        data_pos_q    <= data_pos_d;
        skip_nl_q     <= skip_nl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (fire && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "eeprom_sysinfo_record_parser_macros.svh"

  `ESRP_ASSERT(a_stall_only_when_full, !in_valid_q |-> !in_stall_o)
  `ESRP_ASSERT(a_header_offset, phase_q == PhHeader |-> byte_offset_q < 17'(HeaderBytes))
  `ESRP_ASSERT(a_prefix_range, prefix_cnt_q < 3'(PrefixBytes))
  `ESRP_ASSERT(a_data_pos_range, phase_q == PhData |-> data_pos_q < data_len_q)
  `ESRP_ASSERT_NEXT(a_stopped_silent,
                    fire && !in_q.start_req && phase_q == PhStopped,
                    $stable(phase_q) && !(out_valid_q && !$past(out_valid_q)))

endmodule

`default_nettype wire
